[hw/rtl/imd_pkg.sv]
package imd_pkg;

  localparam int unsigned MaxOrderDefault = 8;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned SizeWidth = 4;

  typedef enum logic [2:0] {
    StLoad,
    StInit,
    StMask,
    StCol,
    StMul,
    StAcc,
    StOut
  } imd_state_e;

endpackage

[hw/rtl/integer_matrix_determinant_core.sv]
// Integer matrix determinant core.
// Load: write matrix_size (register 0, byte address 0) over the APB port while
// idle; a write also drops any partly loaded matrix. Then send the n*n matrix
// elements in row-major order on the input channel (element_value_i,
// valid/stall). Elements are accepted one per cycle while in_stall_o is low.
// After the last element the core computes the determinant division-free by
// building the minors over all column subsets, in increasing mask order, in
// a table of 2^MAX_ORDER words. One shared 32x32 multiplier and one adder do
// the work: each subset takes a setup step (StMask), a visit of each column
// in turn (StCol), a multiply and an accumulate step (StMul, StAcc) per term,
// and a write-back step (StOut).
// The input is stalled during the computation.
// The result word is held on determinant_value_o with out_valid_o until
// out_stall_i is low; loading of the next matrix may start meanwhile, and
// its result waits until the previous word leaves.
// Reset clears the element count, sets the order to 1 and empties the output.
// Store contents are undefined until written; each entry is written before
// it is read. Arithmetic wraps modulo 2^32.
module integer_matrix_determinant_core
  import imd_pkg::*;
#(
  parameter int unsigned MaxOrder = MaxOrderDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [DataWidth-1:0] element_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DataWidth-1:0] determinant_value_o
);

  localparam int unsigned Depth = MaxOrder * MaxOrder;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned OrdW = $clog2(MaxOrder + 1);
  localparam int unsigned ColW = (MaxOrder > 1) ? $clog2(MaxOrder) : 1;
  localparam int unsigned Subsets = 1 << MaxOrder;

  logic [DataWidth-1:0] mat_mem [Depth];
  logic [DataWidth-1:0] minor_mem [Subsets];

  logic [SizeWidth-1:0] size_q;
  logic [CntW-1:0]      count_q, count_d;
  imd_state_e           state_q, state_d;
  logic [MaxOrder-1:0]  mask_q, mask_d, full;
  logic [ColW-1:0]      col_q, col_d;
  logic [OrdW-1:0]      row_q, row_d;
  logic                 pos_q, pos_d;
  logic [DataWidth-1:0] acc_q, acc_d;
  logic [DataWidth-1:0] a_q, m_q, prod_q;
  logic [DataWidth-1:0] res_q;
  logic                 ovalid_q, ovalid_d;
  logic [OrdW-1:0]      order;
  logic [CntW-1:0]      total;
  logic                 cfg_wr, in_acc;
  logic [AddrW-1:0]     rd_addr;
  logic [MaxOrder-1:0]  bit_sel;
  logic                 minor_wr;

  assign pready = 1'b1;
  assign prdata = {{(32-SizeWidth){1'b0}}, size_q};
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

  always_comb begin
    if (size_q == '0) order = OrdW'(1);
    else if (32'(size_q) > MaxOrder) order = OrdW'(MaxOrder);
    else order = OrdW'(size_q);
  end
  assign total = CntW'(32'(order) * 32'(order));
  assign full = MaxOrder'((1 << order) - 1);

  assign in_stall_o = (state_q != StLoad);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;
  assign determinant_value_o = res_q;
  assign bit_sel = MaxOrder'(1) << col_q;
  assign rd_addr = AddrW'(32'(row_q) * 32'(order) + 32'(col_q));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    mask_d = mask_q;
    col_d = col_q;
    row_d = row_q;
    pos_d = pos_q;
    acc_d = acc_q;
    ovalid_d = ovalid_q && out_stall_i;
    minor_wr = 1'b0;
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (count_q + CntW'(1) >= total) begin
            count_d = '0;
            state_d = StInit;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      StInit: begin
        mask_d = MaxOrder'(1);
        state_d = StMask;
      end
      StMask: begin
        row_d = order - OrdW'($countones(mask_q));
        col_d = '0;
        pos_d = 1'b0;
        acc_d = '0;
        state_d = StCol;
      end
      StCol: begin
        if ((mask_q & bit_sel) != '0) begin
          state_d = StMul;
        end else if (32'(col_q) + 1 >= 32'(order)) begin
          state_d = StAcc;
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
      StMul: begin
        state_d = StAcc;
      end
      StAcc: begin
        if ((mask_q & bit_sel) != '0) begin
          acc_d = pos_q ? acc_q - prod_q : acc_q + prod_q;
          pos_d = !pos_q;
        end
        if ((mask_q & bit_sel) != '0 && 32'(col_q) + 1 < 32'(order)) begin
          col_d = col_q + ColW'(1);
          state_d = StCol;
        end else begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (mask_q == full) begin
          if (!ovalid_q) begin
            minor_wr = 1'b1;
            ovalid_d = 1'b1;
            state_d = StLoad;
          end
        end else begin
          minor_wr = 1'b1;
          mask_d = mask_q + MaxOrder'(1);
          state_d = StMask;
        end
      end
      default: state_d = StLoad;
    endcase
    if (cfg_wr) count_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      count_q  <= '0;
      size_q   <= SizeWidth'(1);
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
      if (cfg_wr) size_q <= pwdata[SizeWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    col_q  <= col_d;
    row_q  <= row_d;
    pos_q  <= pos_d;
    acc_q  <= acc_d;
    if (in_acc) mat_mem[count_q[AddrW-1:0]] <= element_value_i;
    if (state_q == StCol) begin
      a_q <= mat_mem[rd_addr];
      m_q <= ((mask_q & ~bit_sel) == '0) ? DataWidth'(1) : minor_mem[mask_q & ~bit_sel];
    end
    if (state_q == StMul) prod_q <= a_q * m_q;
    if (minor_wr) minor_mem[mask_q] <= acc_q;
    if (minor_wr && mask_q == full) res_q <= acc_q;
  end

endmodule

[tb/integer_matrix_determinant_core_tb.sv]
`timescale 1ns / 1ps
module integer_matrix_determinant_core_tb;
  import imd_pkg::*;

  localparam int unsigned MaxOrder = 8;
  localparam logic [1:0] RegMatrixSize = 2'd0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DataWidth-1:0] element_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DataWidth-1:0] determinant_value_o;

  integer_matrix_determinant_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] model_matrix [MaxOrder*MaxOrder];
  logic [31:0] model_minors [1 << MaxOrder];
  logic [3:0] model_size_reg;
  int unsigned model_count;
  logic [31:0] det_expected_q [$];
  int unsigned errors;
  int unsigned words_sent;
  int unsigned dets_seen;
  bit idle_enable;

  function automatic int unsigned order_of(logic [3:0] r);
    if (r == 0) return 1;
    if (r > MaxOrder) return MaxOrder;
    return r;
  endfunction

  function automatic logic [31:0] model_determinant(int unsigned n);
    int unsigned full;
    int unsigned row;
    int unsigned pos;
    logic [31:0] acc;
    logic [31:0] term;
    full = (1 << n) - 1;
    model_minors[0] = 32'd1;
    for (int unsigned m = 1; m <= full; m++) begin
      row = n - $countones(m);
      acc = '0;
      pos = 0;
      for (int unsigned c = 0; c < n; c++) begin
        if (m[c]) begin
          term = model_matrix[row*n + c] * model_minors[m & ~(1 << c)];
          if (pos[0]) acc = acc - term;
          else acc = acc + term;
          pos++;
        end
      end
      model_minors[m] = acc;
    end
    return model_minors[full];
  endfunction

  function automatic void model_accept(logic [31:0] v);
    int unsigned n;
    n = order_of(model_size_reg);
    if (model_count >= n*n) model_count = 0;
    model_matrix[model_count] = v;
    model_count++;
    if (model_count == n*n) begin
      model_count = 0;
      det_expected_q.push_back(model_determinant(n));
    end
  endfunction

  task automatic send_word(logic [31:0] v);
    int unsigned g;
    g = idle_enable ? $urandom_range(0, 7) : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    model_accept(v);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (det_expected_q.size() != 0) @(negedge clk_i);
    repeat (6000) @(negedge clk_i);
  endtask

  task automatic write_size(logic [31:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegMatrixSize;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    model_size_reg = v[3:0];
    model_count = 0;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rand_element(int unsigned kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 20) - 10;
      2: return 32'h8000_0000;
      default: return 32'h7fff_ffff;
    endcase
  endfunction

  task automatic send_matrix(int unsigned n, int unsigned kind);
    for (int unsigned i = 0; i < n*n; i++) send_word(rand_element(kind));
  endtask

  task automatic test_directed();
    write_size(1);
    send_word(32'h8000_0000);
    send_word(32'h7fff_ffff);
    send_word(32'hffff_ffff);
    send_word(32'h0);
    write_size(2);
    send_word(32'h8000_0000); send_word(32'h7fff_ffff);
    send_word(32'h7fff_ffff); send_word(32'h8000_0000);
    write_size(0);
    send_word(32'h1234_5678);
    write_size(15);
    send_matrix(MaxOrder, 3);
    write_size(3);
    send_word(32'd5);
    send_word(32'd7);
    write_size(3);
    send_matrix(3, 1);
  endtask

  task automatic test_random();
    int unsigned n;
    int unsigned start;
    start = words_sent;
    while (words_sent - start < 450) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      write_size(($urandom_range(0, 15) == 0) ? $urandom_range(9, 15) : n);
      idle_enable = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 4)) send_matrix(order_of(model_size_reg), $urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) send_word($urandom);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= idle_enable ? ($urandom_range(0, 7) < 3) : 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      dets_seen++;
      if (det_expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word, actual %h", $time, determinant_value_o);
      end else begin
        if (determinant_value_o !== det_expected_q[0]) begin
          errors++;
          $display("%0t determinant mismatch, expected %h actual %h", $time,
                   det_expected_q[0], determinant_value_o);
        end
        void'(det_expected_q.pop_front());
      end
    end
  end

  initial begin
    errors = 0;
    words_sent = 0;
    dets_seen = 0;
    idle_enable = 1'b1;
    model_size_reg = 4'd1;
    model_count = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    drain();
    if (det_expected_q.size() != 0) errors++;
    $display("Sent %0d words, checked %0d determinants over orders 1 to 8.", words_sent,
             dets_seen);
    if (errors == 0) begin
      $display("PASS integer_matrix_determinant_core");
    end else begin
      $display("FAIL integer_matrix_determinant_core");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL integer_matrix_determinant_core");
    $finish;
  end

endmodule
